FILE: rtl/crt_pkg.sv
// Shared types and codes for the card registry table core.
// Used by crt_ctrl, crt_datapath and card_registry_table_core; no dependencies.
`timescale 1ns / 1ps

package crt_pkg;

   localparam int UID_LOW_W  = 64;
   localparam int UID_HIGH_W = 16;
   localparam int UID_LEN_W  = 4;
   localparam int NAME_W     = 64;
   localparam int EXPIRY_W   = 32;
   localparam int MODE_W     = 3;
   localparam int SLOT_W     = 5;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 6;

   localparam logic [UID_LEN_W-1:0] UID_LEN_MAX = 4'd10;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [UID_LOW_W-1:0]  uid_low;
      logic [UID_HIGH_W-1:0] uid_high;
      logic [UID_LEN_W-1:0]  uid_len;
      logic [NAME_W-1:0]     name;
      logic                  allowed;
      logic [EXPIRY_W-1:0]   expiry;
   } rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SHIFT,
      S_READ,
      S_RESP
   } state_type;

   // Where the response record comes from
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_READ,
      SRC_EDIT,
      SRC_KEY
   } rsp_src_type;

   typedef struct packed {
      logic                load;
      logic                scan_init;
      logic                scan_step;
      logic                shift_init;
      logic                shift_step;
      logic                add_write;
      logic                edit_write;
      logic                total_dec;
      logic                read_issue;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      rsp_src_type         rsp_src;
      logic                rsp_fire;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              hit;
      logic              sweep_done;
      logic              slot_ok;
   } sts_type;

endpackage

FILE: rtl/crt_ctrl.sv
// Sequencer for the card registry table: decodes the operation and steps
// the datapath through scan, shift, read and response. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  crt_pkg::sts_type  sts,
   output crt_pkg::cmd_type  cmd
);
   import crt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = ST_MISSING;
      cmd.rsp_src    = SRC_ZERO;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.mode)
               MODE_LOOKUP, MODE_EDIT, MODE_DELETE: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
               MODE_ADD: begin
                  if (sts.full) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_FULL;
                     state_in       = S_RESP;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               MODE_READ: begin
                  if (sts.slot_ok) begin
                     cmd.read_issue = 1'b1;
                     state_in       = S_READ;
                  end else begin
                     cmd.rsp_load = 1'b1;
                     state_in     = S_RESP;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_RESP;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_RESP;
               case (sts.mode)
                  MODE_ADD: begin
                     cmd.rsp_status = ST_DUP;
                  end
                  MODE_EDIT: begin
                     cmd.edit_write = 1'b1;
                     cmd.rsp_status = ST_OK;
                     cmd.rsp_src    = SRC_EDIT;
                  end
                  MODE_DELETE: begin
                     // capture the victim, then close the gap
                     cmd.rsp_status = ST_OK;
                     cmd.rsp_src    = SRC_READ;
                     cmd.shift_init = 1'b1;
                     state_in       = S_SHIFT;
                  end
                  default: begin
                     cmd.rsp_status = ST_OK;
                     cmd.rsp_src    = SRC_READ;
                  end
               endcase
            end else if (sts.sweep_done) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_RESP;
               if (sts.mode == MODE_ADD) begin
                  cmd.add_write  = 1'b1;
                  cmd.rsp_status = ST_OK;
                  cmd.rsp_src    = SRC_KEY;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (sts.sweep_done) begin
               cmd.total_dec = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_READ: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = ST_OK;
            cmd.rsp_src    = SRC_READ;
            state_in       = S_RESP;
         end
         S_RESP: begin
            cmd.rsp_fire = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/crt_datapath.sv
// Datapath for the card registry table: request key, record memory, scan
// pointer, fill count and response registers. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  crt_pkg::cmd_type                    cmd,
   output crt_pkg::sts_type                    sts,
   input  logic [crt_pkg::MODE_W-1:0]          req_mode,
   input  logic [crt_pkg::UID_LOW_W-1:0]       req_uid_low,
   input  logic [crt_pkg::UID_HIGH_W-1:0]      req_uid_high,
   input  logic [crt_pkg::UID_LEN_W-1:0]       req_uid_len,
   input  logic [crt_pkg::NAME_W-1:0]          req_card_name,
   input  logic                                req_allowed,
   input  logic [crt_pkg::EXPIRY_W-1:0]        req_expiry,
   input  logic [crt_pkg::SLOT_W-1:0]          req_slot,
   output logic [crt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [crt_pkg::SLOT_W-1:0]          rsp_found_slot,
   output logic [crt_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic [crt_pkg::UID_LOW_W-1:0]       rsp_out_uid_low,
   output logic [crt_pkg::UID_HIGH_W-1:0]      rsp_out_uid_high,
   output logic [crt_pkg::UID_LEN_W-1:0]       rsp_out_uid_len,
   output logic [crt_pkg::NAME_W-1:0]          rsp_out_name,
   output logic                                rsp_out_allowed,
   output logic [crt_pkg::EXPIRY_W-1:0]        rsp_out_expiry
);
   import crt_pkg::*;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   rec_type mem [CAPACITY];

   rec_type               key_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [CNT_W-1:0]      total_ff;
   logic [CNT_W-1:0]      total_in;
   logic [CNT_W-1:0]      ptr_ff;
   logic [CNT_W-1:0]      ptr_in;
   logic                  rd_valid_ff;
   logic                  rd_valid_in;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [IDX_W-1:0]      rd_idx_in;
   rec_type               rd_data_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [IDX_W-1:0]      rsp_idx_ff;
   rec_type               rsp_rec_ff;

   rec_type               key_in;
   logic [UID_LEN_W-1:0]  len_clamp;
   logic [UID_LEN_W-1:0]  len_low;
   logic [UID_LOW_W-1:0]  low_mask;
   logic [UID_HIGH_W-1:0] high_mask;
   logic                  ptr_below;
   logic                  issue;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   rec_type               wr_data;
   rec_type               edit_rec;
   rec_type               src_rec;
   logic [IDX_W-1:0]      src_idx;
   logic                  match;
   logic [WIDE_W-1:0]     slot_wide;
   logic [WIDE_W-1:0]     total_wide;
   logic [WIDE_W-1:0]     idx_wide;
   logic [IDX_W-1:0]      slot_idx;

   // Canonical key: clamp the length and zero bytes past it
   always_comb begin
      len_clamp = (req_uid_len > UID_LEN_MAX) ? UID_LEN_MAX : req_uid_len;
      len_low   = (len_clamp > 4'd8) ? 4'd8 : len_clamp;
      low_mask  = ~({UID_LOW_W{1'b1}} >> {len_low, 3'b000});
      if (len_clamp == UID_LEN_MAX) begin
         high_mask = {UID_HIGH_W{1'b1}};
      end else if (len_clamp == 4'd9) begin
         high_mask = 16'hFF00;
      end else begin
         high_mask = '0;
      end
      key_in.uid_low  = req_uid_low & low_mask;
      key_in.uid_high = req_uid_high & high_mask;
      key_in.uid_len  = len_clamp;
      key_in.name     = req_card_name;
      key_in.allowed  = req_allowed;
      key_in.expiry   = req_expiry;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= key_in;
         mode_ff <= req_mode;
         slot_ff <= req_slot;
      end
   end

   assign slot_wide  = WIDE_W'(slot_ff);
   assign total_wide = WIDE_W'(total_ff);
   assign slot_idx   = slot_wide[IDX_W-1:0];

   assign ptr_below = (ptr_ff < total_ff);
   assign issue     = (cmd.scan_step || cmd.shift_step) && ptr_below;
   assign match     = (rd_data_ff.uid_len == key_ff.uid_len) &&
                      (rd_data_ff.uid_low == key_ff.uid_low) &&
                      (rd_data_ff.uid_high == key_ff.uid_high);

   assign sts.mode       = mode_ff;
   assign sts.full       = (total_ff >= CNT_W'(CAPACITY));
   assign sts.hit        = rd_valid_ff && match;
   assign sts.sweep_done = !rd_valid_ff && !ptr_below;
   assign sts.slot_ok    = (slot_wide < total_wide) && (slot_wide < WIDE_W'(CAPACITY));

   // Sweep pointer and read-tag tracking
   always_comb begin
      ptr_in      = ptr_ff;
      rd_valid_in = rd_valid_ff;
      rd_idx_in   = rd_idx_ff;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[IDX_W-1:0];
      if (cmd.scan_init) begin
         ptr_in      = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.shift_init) begin
         ptr_in      = CNT_W'(rd_idx_ff) + 1'b1;
         rd_valid_in = 1'b0;
      end else if (cmd.scan_step || cmd.shift_step) begin
         rd_valid_in = issue;
         if (issue) begin
            ptr_in    = ptr_ff + 1'b1;
            rd_idx_in = ptr_ff[IDX_W-1:0];
            rd_en     = 1'b1;
         end
      end else if (cmd.read_issue) begin
         rd_idx_in = slot_idx;
         rd_addr   = slot_idx;
         rd_en     = 1'b1;
      end
   end

   always_comb begin
      edit_rec         = rd_data_ff;
      edit_rec.name    = key_ff.name;
      edit_rec.allowed = key_ff.allowed;
      edit_rec.expiry  = key_ff.expiry;
   end

   // Single write port: append, in-place edit, or shift one entry down
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data_ff;
      if (cmd.add_write) begin
         wr_en   = 1'b1;
         wr_addr = total_ff[IDX_W-1:0];
         wr_data = key_ff;
      end else if (cmd.edit_write) begin
         wr_en   = 1'b1;
         wr_data = edit_rec;
      end else if (cmd.shift_step && rd_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.add_write) begin
         total_in = total_ff + 1'b1;
      end else if (cmd.total_dec) begin
         total_in = total_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         ptr_ff      <= '0;
         rd_valid_ff <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         total_ff    <= total_in;
         ptr_ff      <= ptr_in;
         rd_valid_ff <= rd_valid_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   always_comb begin
      src_rec = '0;
      src_idx = '0;
      case (cmd.rsp_src)
         SRC_READ: begin
            src_rec = rd_data_ff;
            src_idx = rd_idx_ff;
         end
         SRC_EDIT: begin
            src_rec = edit_rec;
            src_idx = rd_idx_ff;
         end
         SRC_KEY: begin
            src_rec = key_ff;
            src_idx = total_ff[IDX_W-1:0];
         end
         default: begin
            src_rec = '0;
            src_idx = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_idx_ff    <= src_idx;
         rsp_rec_ff    <= src_rec;
      end
   end

   assign idx_wide = WIDE_W'(rsp_idx_ff);

   assign rsp_status       = rsp_status_ff;
   assign rsp_found_slot   = idx_wide[SLOT_W-1:0];
   assign rsp_entry_count  = total_wide[COUNT_W-1:0];
   assign rsp_out_uid_low  = rsp_rec_ff.uid_low;
   assign rsp_out_uid_high = rsp_rec_ff.uid_high;
   assign rsp_out_uid_len  = rsp_rec_ff.uid_len;
   assign rsp_out_name     = rsp_rec_ff.name;
   assign rsp_out_allowed  = rsp_rec_ff.allowed;
   assign rsp_out_expiry   = rsp_rec_ff.expiry;

endmodule

FILE: rtl/card_registry_table_core.sv
// Card registry table: compacting table of card records with lookup, add, edit, delete, read.
// A read passes through dispatch, a memory read and the response state; a rejected request
// goes from dispatch straight to the response. Lookup, add and edit sweep from slot 0 to a hit
// or the end of the table; delete then shifts the later entries down to close the gap.
// One transaction at a time: the next is accepted in the cycle after rsp_valid.
// Reset: synchronous; clears the entry count and controller, no memory clear pass needed.
`timescale 1ns / 1ps

module card_registry_table_core #(
   parameter int CAPACITY = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [crt_pkg::MODE_W-1:0]          req_mode,
   input  logic [crt_pkg::UID_LOW_W-1:0]       req_uid_low,
   input  logic [crt_pkg::UID_HIGH_W-1:0]      req_uid_high,
   input  logic [crt_pkg::UID_LEN_W-1:0]       req_uid_len,
   input  logic [crt_pkg::NAME_W-1:0]          req_card_name,
   input  logic                                req_allowed,
   input  logic [crt_pkg::EXPIRY_W-1:0]        req_expiry,
   input  logic [crt_pkg::SLOT_W-1:0]          req_slot,
   output logic                                rsp_valid,
   output logic [crt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [crt_pkg::SLOT_W-1:0]          rsp_found_slot,
   output logic [crt_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic [crt_pkg::UID_LOW_W-1:0]       rsp_out_uid_low,
   output logic [crt_pkg::UID_HIGH_W-1:0]      rsp_out_uid_high,
   output logic [crt_pkg::UID_LEN_W-1:0]       rsp_out_uid_len,
   output logic [crt_pkg::NAME_W-1:0]          rsp_out_name,
   output logic                                rsp_out_allowed,
   output logic [crt_pkg::EXPIRY_W-1:0]        rsp_out_expiry
);
   import crt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   crt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   crt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_uid_low      (req_uid_low),
      .req_uid_high     (req_uid_high),
      .req_uid_len      (req_uid_len),
      .req_card_name    (req_card_name),
      .req_allowed      (req_allowed),
      .req_expiry       (req_expiry),
      .req_slot         (req_slot),
      .rsp_status       (rsp_status),
      .rsp_found_slot   (rsp_found_slot),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_out_uid_low  (rsp_out_uid_low),
      .rsp_out_uid_high (rsp_out_uid_high),
      .rsp_out_uid_len  (rsp_out_uid_len),
      .rsp_out_name     (rsp_out_name),
      .rsp_out_allowed  (rsp_out_allowed),
      .rsp_out_expiry   (rsp_out_expiry)
   );

   assign rsp_valid = cmd.rsp_fire;

`ifndef SYNTHESIS
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after response");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_found_slot == '0 && rsp_out_uid_len == '0 && rsp_out_uid_low == '0))
      else $error("failed transaction returned nonzero entry fields");

   a_no_append_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.add_write |-> !sts.full)
      else $error("append issued on full table");
`endif

endmodule
